// File: rtl/core/exact_double_int64_bit_converter_top_macros.svh
// Assertion macros for the exact double/int64 converter checker.
// Used by the checker file only; no other dependencies.
`ifndef EXACT_DOUBLE_INT64_BIT_CONVERTER_TOP_MACROS_SVH
`define EXACT_DOUBLE_INT64_BIT_CONVERTER_TOP_MACROS_SVH

// Assert a property on the rising clock, disabled while reset is low.
`define EDI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the rising clock that must also hold during reset.
`define EDI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/edi_pkg.sv
// Package for the exact double/int64 converter: status codes, modes, field widths.
// No dependencies.
`default_nettype none
package edi_pkg;
    localparam int WordW = 64;
    localparam int StatusW = 2;

    typedef logic [WordW-1:0] t_word;

    typedef enum logic [StatusW-1:0] {
        ST_OK      = 2'd0,
        ST_NOT_INT = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    localparam logic MODE_D2I = 1'b0;
    localparam logic MODE_I2D = 1'b1;
endpackage
`default_nettype wire

// File: rtl/core/exact_double_int64_bit_converter_top.sv
// Top level of the exact double/int64 converter.
// Depends on edi_pkg and edi_conv.
`default_nettype none
// One word in, one word out, one word per cycle sustained.
// A word is taken at a rising edge with start high; busy is never raised, so start may
// be held high every cycle. The operand sits in an input register, the conversion runs
// as one combinational pass (priority encoders and a barrel shifter in edi_conv), and
// the result register drives o_result_bits / o_status with o_done high for exactly one
// cycle. The receiver cannot stall; every result is shown once. A failed conversion
// (fraction, NaN, out of range, >53 significant bits) reads zero with a nonzero status.
module exact_double_int64_bit_converter_top import edi_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_mode,
    input  wire logic [WordW-1:0]    i_value_bits,
    output logic                     o_done,
    output logic      [WordW-1:0]    o_result_bits,
    output logic      [StatusW-1:0]  o_status
);
    logic               r_in_vld;
    logic               r_mode;
    logic [WordW-1:0]   r_value;
    logic               r_out_vld;
    logic [WordW-1:0]   r_result;
    logic [StatusW-1:0] r_status;
    logic [WordW-1:0]   n_result;
    logic [StatusW-1:0] n_status;

    assign busy = 1'b0;

    edi_conv u_conv (
        .i_mode        (r_mode),
        .i_value_bits  (r_value),
        .o_result_bits (n_result),
        .o_status      (n_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mode  <= i_mode;
            r_value <= i_value_bits;
        end
        r_result <= n_result;
        r_status <= n_status;
    end

    assign o_done        = r_out_vld;
    assign o_result_bits = r_result;
    assign o_status      = r_status;
endmodule
`default_nettype wire

// File: rtl/core/edi_conv.sv
// Combinational conversion datapath: double->int64 and int64->double, exact only.
// Depends on edi_pkg.
`default_nettype none
module edi_conv import edi_pkg::*; (
    input  wire logic                i_mode,
    input  wire logic [WordW-1:0]    i_value_bits,
    output logic      [WordW-1:0]    o_result_bits,
    output logic      [StatusW-1:0]  o_status
);
    // double -> int
    logic        d_neg;
    logic [10:0] d_ex;
    logic [51:0] d_frac;
    logic [52:0] d_mant;
    logic [63:0] d_mag;
    logic [63:0] d_shl;
    logic [52:0] d_lost;
    logic [5:0]  d_rsh;
    logic [5:0]  d_lsh;
    t_status     d_st;
    logic [63:0] d_res;

    // int -> double
    logic        i_neg;
    logic [63:0] i_mag;
    logic [5:0]  i_msb;
    logic [5:0]  i_lsb;
    logic [63:0] i_norm;
    t_status     i_st;
    logic [63:0] i_res;

    always_comb begin
        d_neg  = i_value_bits[63];
        d_ex   = i_value_bits[62:52];
        d_frac = i_value_bits[51:0];
        d_mant = {1'b1, d_frac};
        // right shift 1075-ex for ex in 1023..1074 -> 1..52; left ex-1075 for 1075..1085
        d_rsh  = 6'(11'd1075 - d_ex);
        d_lsh  = 6'(d_ex - 11'd1075);
        d_lost = d_mant & ((53'd1 << d_rsh) - 53'd1);
        d_shl  = {11'd0, d_mant} << d_lsh;
        d_mag  = '0;
        d_st   = ST_OK;
        d_res  = '0;
        if (d_ex == 11'h7FF) begin
            d_st = (d_frac != '0) ? ST_NOT_INT : ST_RANGE;
        end else if (d_ex == 11'd0) begin
            d_st = (d_frac != '0) ? ST_NOT_INT : ST_OK;
        end else if (d_ex < 11'd1023) begin
            d_st = ST_NOT_INT;
        end else if (d_ex < 11'd1075) begin
            if (d_lost != '0) begin
                d_st = ST_NOT_INT;
            end else begin
                d_mag = {11'd0, d_mant >> d_rsh};
            end
        end else if (d_ex >= 11'd1086) begin
            if (d_neg && d_ex == 11'd1086 && d_frac == '0) begin
                d_res = 64'h8000_0000_0000_0000;
            end else begin
                d_st = ST_RANGE;
            end
        end else begin
            d_mag = d_shl;
        end
        if (d_st == ST_OK && d_ex < 11'd1086) begin
            d_res = d_neg ? (64'd0 - d_mag) : d_mag;
        end
    end

    always_comb begin
        i_neg = i_value_bits[63];
        i_mag = i_neg ? (64'd0 - i_value_bits) : i_value_bits;
        i_msb = '0;
        for (int k = 0; k < WordW; k++) begin
            if (i_mag[k]) i_msb = 6'(k);
        end
        i_lsb = '0;
        for (int k = WordW - 1; k >= 0; k--) begin
            if (i_mag[k]) i_lsb = 6'(k);
        end
        i_norm = i_mag << (6'd63 - i_msb);
        i_st   = ST_OK;
        i_res  = '0;
        if (i_mag != '0) begin
            if ((i_msb - i_lsb) >= 6'd53) begin
                i_st = ST_RANGE;
            end else begin
                i_res = {i_neg, 11'(11'd1023 + {5'd0, i_msb}), i_norm[62:11]};
            end
        end
    end

    always_comb begin
        if (i_mode == MODE_I2D) begin
            o_status      = i_st;
            o_result_bits = (i_st == ST_OK) ? i_res : '0;
        end else begin
            o_status      = d_st;
            o_result_bits = (d_st == ST_OK) ? d_res : '0;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/edi_checker.sv
// Port-level checker for the exact double/int64 converter, bound to the top level.
// Depends on edi_pkg and the macros header.
`default_nettype none
`include "exact_double_int64_bit_converter_top_macros.svh"
module edi_checker import edi_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_done,
    input wire logic [WordW-1:0]   o_result_bits,
    input wire logic [StatusW-1:0] o_status
);
    `EDI_ASSERT(a_done_follows, i_clk, i_rst_n, (start && !busy) |=> ##1 o_done, "accepted word gave no result")
    `EDI_ASSERT(a_no_spurious, i_clk, i_rst_n, (o_done && $past(i_rst_n, 2)) |-> $past(start && !busy, 2), "result without word")
    `EDI_ASSERT(a_err_zero, i_clk, i_rst_n, (o_done && o_status != ST_OK) |-> (o_result_bits == '0), "error result not zero")
    `EDI_ASSERT(a_status_range, i_clk, i_rst_n, o_done |-> (o_status != 2'd3), "illegal status")
    `EDI_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_done, "done right after reset")
endmodule

bind exact_double_int64_bit_converter_top edi_checker u_edi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_result_bits (o_result_bits),
    .o_status      (o_status)
);
`default_nettype wire

// File: verif/tb.sv
// Testbench for exact_double_int64_bit_converter_top: directed table plus random words,
// checked against typed-in values or a predictor. Depends on edi_pkg and the RTL only.
`default_nettype none
module tb import edi_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       mode;
        logic [63:0] value;
        logic       has_known;   // table row carries a typed-in expectation
        logic [63:0] known_bits;
        logic [1:0]  known_st;
    } t_row;

    typedef struct packed {
        logic [63:0] bits;
        logic [1:0]  st;
    } t_conv;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_mode;
    logic [63:0] i_value_bits;
    logic        o_done;
    logic [63:0] o_result_bits;
    logic [1:0]  o_status;

    exact_double_int64_bit_converter_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_value_bits(i_value_bits),
        .o_done(o_done), .o_result_bits(o_result_bits), .o_status(o_status)
    );

    t_conv pending_q[$];
    int    fail_cnt = 0;
    int    words_sent = 0;
    int    words_checked = 0;
    int    idle_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Generous wall: 653 words, even with idle gaps, finish far below this.
    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    // Index of the highest set bit; v must be nonzero.
    function automatic int top_bit(logic [63:0] v);
        int p;
        p = 0;
        for (int k = 0; k < 64; k++)
            if (v[k]) p = k;
        return p;
    endfunction

    function automatic int low_bit(logic [63:0] v);
        int p;
        p = 63;
        for (int k = 63; k >= 0; k--)
            if (v[k]) p = k;
        return p;
    endfunction

    // Predicted conversion of one word.
    function automatic t_conv convert_word(logic mode, logic [63:0] x);
        t_conv       r;
        logic        neg;
        logic [10:0] ex;
        logic [51:0] frac;
        logic [63:0] mant, mag;
        int          e, p, t;
        r.bits = '0;
        r.st = ST_OK;
        neg = x[63];
        if (mode == MODE_D2I) begin
            ex = x[62:52];
            frac = x[51:0];
            if (ex == 11'h7FF) begin
                r.st = (frac != 0) ? ST_NOT_INT : ST_RANGE;
            end else if (ex == 0) begin
                r.st = (frac != 0) ? ST_NOT_INT : ST_OK;
            end else begin
                mant = {11'd0, 1'b1, frac};
                e = int'(ex) - 1075;
                if (e < 0) begin
                    if (-e >= 64) r.st = ST_NOT_INT;
                    else if ((mant & ((64'd1 << -e) - 64'd1)) != 0) r.st = ST_NOT_INT;
                    else r.bits = neg ? -(mant >> -e) : (mant >> -e);
                end else if (int'(ex) - 1023 >= 63) begin
                    // only -2^63 fits at this magnitude
                    if (neg && ex == 11'd1086 && frac == 0) r.bits = 64'h8000_0000_0000_0000;
                    else r.st = ST_RANGE;
                end else begin
                    mag = mant << e;
                    r.bits = neg ? -mag : mag;
                end
            end
        end else begin
            mag = neg ? -x : x;
            if (mag != 0) begin
                p = top_bit(mag);
                t = low_bit(mag);
                if (p - t >= 53) r.st = ST_RANGE;
                else begin
                    mant = (p <= 52) ? (mag << (52 - p)) : (mag >> (p - 52));
                    r.bits = {neg, 11'(p + 1023), mant[51:0]};
                end
            end
        end
        if (r.st != ST_OK) r.bits = '0;
        return r;
    endfunction

    // Result checker: every strobed result pops the oldest expectation.
    always @(posedge i_clk) begin
        t_conv want;
        if (i_rst_n && o_done) begin
            if (pending_q.size() == 0) begin
                $error("result with nothing expected: bits=%h status=%0d",
                       o_result_bits, o_status);
                fail_cnt++;
            end else begin
                want = pending_q.pop_front();
                words_checked++;
                if (o_result_bits !== want.bits) begin
                    $error("result_bits: expected %h actual %h", want.bits, o_result_bits);
                    fail_cnt++;
                end
                if (o_status !== want.st) begin
                    $error("status: expected %0d actual %0d", want.st, o_status);
                    fail_cnt++;
                end
            end
        end
    end

    // Present one word at the falling edge, hold until taken at a rising edge.
    // Start stays high across back-to-back words; it only drops on an idle gap.
    task automatic send_word(logic mode, logic [63:0] v, t_conv want);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_value_bits <= v;
        do @(posedge i_clk); while (busy);
        pending_q.push_back(want);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Random operand biased toward well-formed cases of the chosen mode.
    function automatic logic [63:0] pick_value(logic mode);
        logic [63:0] v;
        int          s, w;
        v = {$urandom, $urandom};
        case ($urandom_range(5, 0))
            0: ;                                             // raw noise
            1: if (mode == MODE_D2I)                         // double, exponent 1023..1086
                   v[62:52] = 11'($urandom_range(1086, 1023));
               else begin                                    // short mantissa, exact
                   w = $urandom_range(53, 1);
                   s = $urandom_range(63 - w, 0);
                   v = ((v & ((64'd1 << w) - 1)) | (64'd1 << (w - 1))) << s;
               end
            2: if (mode == MODE_D2I) v[62:52] = 11'($urandom_range(1100, 1060));
               else begin                                    // span around 53 bits
                   w = $urandom_range(55, 52);
                   s = $urandom_range(63 - w, 0);
                   v = ((v & ((64'd1 << w) - 1)) | (64'd1 << (w - 1)) | 64'd1) << s;
               end
            3: if (mode == MODE_D2I) begin                   // integer, no fraction bits
                   v[62:52] = 11'($urandom_range(1074, 1023));
                   v = v & ~((64'd1 << (1075 - int'(v[62:52]))) - 64'd1);
               end else v = -(64'd1 << $urandom_range(63, 0));
            4: if (mode == MODE_D2I) v[62:52] = $urandom_range(1) ? 11'h7FF : 11'd0;
               else v = {$urandom_range(1) ? 11'h7FF : 11'h000, v[52:0]};
            default: if (mode == MODE_D2I) v[62:52] = 11'($urandom_range(1022, 900));
        endcase
        return v;
    endfunction

    t_row stim_tbl[] = '{
        // +0 / -0 to integer 0
        '{MODE_D2I, 64'h0000_0000_0000_0000, 1'b1, 64'd0, ST_OK},
        '{MODE_D2I, 64'h8000_0000_0000_0000, 1'b1, 64'd0, ST_OK},
        // 1.0 and -1.0
        '{MODE_D2I, 64'h3FF0_0000_0000_0000, 1'b1, 64'd1, ST_OK},
        '{MODE_D2I, 64'hBFF0_0000_0000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ST_OK},
        // 0.5 has a fraction; subnormal too
        '{MODE_D2I, 64'h3FE0_0000_0000_0000, 1'b1, 64'd0, ST_NOT_INT},
        '{MODE_D2I, 64'h0000_0000_0000_0001, 1'b1, 64'd0, ST_NOT_INT},
        // quiet and signaling NaN, negative NaN with full payload
        '{MODE_D2I, 64'h7FF8_0000_0000_0000, 1'b1, 64'd0, ST_NOT_INT},
        '{MODE_D2I, 64'h7FF0_0000_0000_0001, 1'b1, 64'd0, ST_NOT_INT},
        '{MODE_D2I, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0, ST_NOT_INT},
        // infinities
        '{MODE_D2I, 64'h7FF0_0000_0000_0000, 1'b1, 64'd0, ST_RANGE},
        '{MODE_D2I, 64'hFFF0_0000_0000_0000, 1'b1, 64'd0, ST_RANGE},
        // 2^63 out of range, -2^63 exact, largest below 2^63
        '{MODE_D2I, 64'h43E0_0000_0000_0000, 1'b1, 64'd0, ST_RANGE},
        '{MODE_D2I, 64'hC3E0_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0000, ST_OK},
        '{MODE_D2I, 64'hC3E0_0000_0000_0001, 1'b1, 64'd0, ST_RANGE},
        '{MODE_D2I, 64'h43DF_FFFF_FFFF_FFFF, 1'b0, 64'd0, ST_OK},
        '{MODE_D2I, 64'h4330_0000_0000_0001, 1'b0, 64'd0, ST_OK},
        // integer side: zero, one, -1, extremes, 53 vs 54 significant bits
        '{MODE_I2D, 64'h0000_0000_0000_0000, 1'b1, 64'd0, ST_OK},
        '{MODE_I2D, 64'h0000_0000_0000_0001, 1'b1, 64'h3FF0_0000_0000_0000, ST_OK},
        '{MODE_I2D, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hBFF0_0000_0000_0000, ST_OK},
        '{MODE_I2D, 64'h8000_0000_0000_0000, 1'b1, 64'hC3E0_0000_0000_0000, ST_OK},
        '{MODE_I2D, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 64'd0, ST_RANGE},
        '{MODE_I2D, 64'h001F_FFFF_FFFF_FFFF, 1'b0, 64'd0, ST_OK},
        '{MODE_I2D, 64'h003F_FFFF_FFFF_FFFF, 1'b1, 64'd0, ST_RANGE},
        '{MODE_I2D, 64'h7FFF_FFFF_FFFF_F800, 1'b0, 64'd0, ST_OK},
        '{MODE_I2D, 64'h8000_0000_0000_0001, 1'b1, 64'd0, ST_RANGE}
    };

    initial begin
        t_conv want;
        logic  m;
        int    idle_sel[4];
        idle_sel = '{0, 63, 0, 30};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_mode = MODE_D2I;
        i_value_bits = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: typed-in expectation where present, predictor elsewhere.
        foreach (stim_tbl[k]) begin
            want = convert_word(stim_tbl[k].mode, stim_tbl[k].value);
            if (stim_tbl[k].has_known) begin
                want.bits = stim_tbl[k].known_bits;
                want.st = stim_tbl[k].known_st;
            end
            send_word(stim_tbl[k].mode, stim_tbl[k].value, want);
        end

        // Let the pipeline drain fully once before the random phases.
        start <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);

        // Random phases: no gaps, heavy gaps, none again, moderate gaps.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = idle_sel[ph];
            repeat (157) begin
                m = 1'($urandom_range(1, 0));
                begin
                    logic [63:0] v;
                    v = pick_value(m);
                    send_word(m, v, convert_word(m, v));
                end
            end
        end
        start <= 1'b0;

        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (6) @(posedge i_clk);
        $display("Converted %0d words both ways, %0d results checked; covered zeros, NaN,",
                 words_sent, words_checked);
        $display("infinities, range edges and 53-bit limits under several idle mixes.");
        if (fail_cnt == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
